/* rtl/core/mbrr_pkg.sv */
// shared types and constants for the mono bitmap row realigner
package mbrr_pkg;

  localparam int unsigned WIDTH_W    = 15;
  localparam int unsigned ROWS_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [WIDTH_W-1:0] MAX_ROW_BITS = 15'd16384;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 2'd3;

  // output queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  typedef struct packed {
    logic [2:0]         bit_offset;
    logic [WIDTH_W-1:0] row_width_bits;
    logic [ROWS_W-1:0]  row_count;
    logic [7:0]         invert_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_end;
    logic       image_end;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } step_t;

endpackage

/* rtl/core/mbrr_align_unit.sv */
// row state and combinational shift, join and tail-mask logic
module mbrr_align_unit import mbrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] src_byte_i,
  input  cfg_t       cfg_i,
  output step_t      step_o
);

  logic [7:0]         held_q, held_d;
  logic               have_held_q, have_held_d;
  logic [WIDTH_W-1:0] bits_left_q, bits_left_d;
  logic [ROWS_W-1:0]  rows_done_q, rows_done_d;
  logic [2:0]         sbit_q, sbit_d;

  logic               start;
  logic [WIDTH_W-1:0] width_clamped;
  logic [WIDTH_W-1:0] bl;
  logic [WIDTH_W-1:0] bl_sub;
  logic [2:0]         s;
  logic               hh;
  logic [3:0]         s_inv;
  logic [7:0]         joined;
  logic [7:0]         tail_a;
  logic [7:0]         tail_b;
  logic [7:0]         shifted_b;
  logic               row_done;
  logic [ROWS_W-1:0]  rc;
  logic [ROWS_W-1:0]  rows_inc;
  logic               img_done;

  always_comb begin
    width_clamped = cfg_i.row_width_bits;
    if (cfg_i.row_width_bits == '0) begin
      width_clamped = WIDTH_W'(1);
    end else if (cfg_i.row_width_bits > MAX_ROW_BITS) begin
      width_clamped = MAX_ROW_BITS;
    end
  end

  assign start  = (bits_left_q == '0);
  assign bl     = start ? width_clamped : bits_left_q;
  assign s      = start ? cfg_i.bit_offset : sbit_q;
  assign hh     = start ? 1'b0 : have_held_q;
  assign bl_sub = (bl > WIDTH_W'(8)) ? (bl - WIDTH_W'(8)) : '0;
  assign s_inv  = 4'd8 - {1'b0, s};

  assign shifted_b = src_byte_i << s;
  assign joined    = ((held_q << s) | (src_byte_i >> s_inv)) ^ cfg_i.invert_mask;
  // tail masked to the pixels left; first form uses the whole width, second the rest
  assign tail_a    = (shifted_b ^ cfg_i.invert_mask) & 8'((16'hff00 >> bl[3:0]));
  assign tail_b    = (shifted_b ^ cfg_i.invert_mask) & 8'((16'hff00 >> bl_sub[3:0]));

  assign rc       = (cfg_i.row_count == '0) ? ROWS_W'(1) : cfg_i.row_count;
  assign rows_inc = rows_done_q + ROWS_W'(1);
  assign img_done = (rows_inc >= rc);

  always_comb begin
    step_o      = '0;
    held_d      = held_q;
    have_held_d = hh;
    bits_left_d = bl;
    sbit_d      = s;
    row_done    = 1'b0;

    if (s == 3'd0) begin
      step_o.num           = 2'd1;
      step_o.res0.out_byte = src_byte_i ^ cfg_i.invert_mask;
      bits_left_d          = bl_sub;
      row_done             = (bl_sub == '0);
    end else if (hh) begin
      step_o.num           = 2'd1;
      step_o.res0.out_byte = joined;
      bits_left_d          = bl_sub;
      if (bl_sub == '0) begin
        row_done = 1'b1;
      end else if (({1'b0, bl_sub} + (WIDTH_W+1)'(s)) <= (WIDTH_W+1)'(8)) begin
        step_o.num           = 2'd2;
        step_o.res1.out_byte = tail_b;
        bits_left_d          = '0;
        row_done             = 1'b1;
      end else begin
        held_d = src_byte_i;
      end
    end else begin
      if (({1'b0, bl} + (WIDTH_W+1)'(s)) > (WIDTH_W+1)'(8)) begin
        held_d      = src_byte_i;
        have_held_d = 1'b1;
      end else begin
        step_o.num           = 2'd1;
        step_o.res0.out_byte = tail_a;
        bits_left_d          = '0;
        row_done             = 1'b1;
      end
    end

    rows_done_d = rows_done_q;
    if (row_done) begin
      have_held_d = 1'b0;
      held_d      = '0;
      rows_done_d = img_done ? '0 : rows_inc;
      if (step_o.num == 2'd2) begin
        step_o.res1.row_end   = 1'b1;
        step_o.res1.image_end = img_done;
      end else begin
        step_o.res0.row_end   = 1'b1;
        step_o.res0.image_end = img_done;
      end
    end

    if (step_o.num == 2'd2) begin
      step_o.res1.run_last = 1'b1;
    end else if (step_o.num == 2'd1) begin
      step_o.res0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      have_held_q <= 1'b0;
      bits_left_q <= '0;
      rows_done_q <= '0;
      sbit_q      <= '0;
    end else if (en_i) begin
      held_q      <= held_d;
      have_held_q <= have_held_d;
      bits_left_q <= bits_left_d;
      rows_done_q <= rows_done_d;
      sbit_q      <= sbit_d;
    end
  end

endmodule

/* rtl/core/mbrr_out_fifo.sv */
// small result queue that takes up to two entries and gives one per cycle while the reader is ready
module mbrr_out_fifo import mbrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_num_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       room2_o,
  output logic       valid_o,
  input  logic       ready_i,
  output result_t    data_o
);

  result_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr_p1;

  assign valid_o   = (cnt_q != '0);
  assign pop       = valid_o && ready_i;
  assign data_o    = mem_q[rd_ptr_q];
  assign room2_o   = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_num_i);
    rd_ptr_d = pop ? (rd_ptr_q + PTR_W'(1)) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push_num_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr_p1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/core/mono_bitmap_row_realigner_core.sv */
// top level of the mono bitmap row realigner: config registers, input stage, queue
// path: a source byte is held in the input register, passes the combinational align unit
//   and is written into the result queue, from whose head its output bytes are offered
// throughput: one source byte per cycle while the queue has room for two results;
//   a row tail with two output bytes leaves through the queue's single read port
// reset: asynchronous active low; clears row state, counters and queue, sets config to defaults
module mono_bitmap_row_realigner_core import mbrr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // source byte channel
  input  logic                  src_valid_i,
  output logic                  src_ready_o,
  input  logic [7:0]            src_byte_i,
  // output byte channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  row_end_o,
  output logic                  image_end_o,
  output logic                  run_last_o
);

  cfg_t       cfg_q;
  logic [7:0] byte_q;
  logic       byte_vld_q, byte_vld_d;
  logic       room2;
  logic       process;
  logic       src_take;
  step_t      step;
  logic [1:0] push_num;
  result_t    head;

  // config registers; row width and offset are sampled by the align unit at row start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_offset     <= '0;
      cfg_q.row_width_bits <= WIDTH_W'(8);
      cfg_q.row_count      <= ROWS_W'(1);
      cfg_q.invert_mask    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BIT_OFFSET: cfg_q.bit_offset     <= cfg_data_i[2:0];
        CFG_ROW_WIDTH:  cfg_q.row_width_bits <= cfg_data_i[WIDTH_W-1:0];
        CFG_ROW_COUNT:  cfg_q.row_count      <= cfg_data_i[ROWS_W-1:0];
        CFG_INVERT:     cfg_q.invert_mask    <= cfg_data_i[7:0];
        default:        cfg_q                <= cfg_q;
      endcase
    end
  end

  // input register: the held byte is processed once the queue has room for two results
  assign process     = byte_vld_q && room2;
  assign src_ready_o = !byte_vld_q || process;
  assign src_take    = src_valid_i && src_ready_o;

  always_comb begin
    byte_vld_d = byte_vld_q;
    if (src_take) begin
      byte_vld_d = 1'b1;
    end else if (process) begin
      byte_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else begin
      byte_vld_q <= byte_vld_d;
    end
  end

  // payload register needs no reset
  always_ff @(posedge clk_i) begin
    if (src_take) begin
      byte_q <= src_byte_i;
    end
  end

  // shift, join and mask stage with the row state
  mbrr_align_unit u_align (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (process),
    .src_byte_i (byte_q),
    .cfg_i      (cfg_q),
    .step_o     (step)
  );

  // a holding step pushes nothing
  assign push_num = process ? step.num : 2'd0;

  // result queue parts the output side from the input side
  mbrr_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .push0_i    (step.res0),
    .push1_i    (step.res1),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (head)
  );

  assign out_byte_o  = head.out_byte;
  assign row_end_o   = head.row_end;
  assign image_end_o = head.image_end;
  assign run_last_o  = head.run_last;

endmodule
